[design/ohash_pkg.sv]
// ----------------------------------------------------------------------------
// ohash_pkg
// Shared types and constants for the open-addressing hash table: field
// widths, action, status and slot mark codes, and controller/datapath structs.
// ----------------------------------------------------------------------------
package ohash_pkg;

	localparam int ACT_W  = 2;
	localparam int KEY_W  = 17;
	localparam int PAY_W  = 32;
	localparam int ST_W   = 2;
	localparam int SLOT_W = 3;
	localparam int CFG_W  = 4;

	// golden ratio fraction as an unsigned 0.32 value
	localparam logic [31:0] GOLDEN_Q32 = 32'd2654435769;
	localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

	localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
	localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd2;

	localparam logic [ST_W-1:0] ST_OK      = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
	localparam logic [ST_W-1:0] ST_MISSING = 2'd2;

	typedef enum logic [1:0] {
		MARK_EMPTY   = 2'd0,
		MARK_USED    = 2'd1,
		MARK_DELETED = 2'd2
	} mark_t;

	typedef struct packed {
		mark_t             mark;
		logic [KEY_W-1:0]  key;
		logic [PAY_W-1:0]  payload;
	} entry_t;

	typedef struct packed {
		logic clear;
		logic load_in;
		logic hash1;
		logic hash2;
		logic read;
		logic check;
		logic load_out;
	} ctl_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic check_done;
		logic out_free;
	} ctl_sts_t;

endpackage

[design/ohash_ctrl.sv]
// ----------------------------------------------------------------------------
// ohash_ctrl
// Sequencer for the hash table: clearing pass after reset, hashing steps,
// one probe per cycle, then hand-off of the result to the output register.
// ----------------------------------------------------------------------------
module ohash_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ohash_pkg::ctl_sts_t sts,
	output ohash_pkg::ctl_cmd_t cmd
);
	import ohash_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH1,
		S_HASH2,
		S_READ,
		S_CHECK,
		S_OUT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			case (state_q)
				S_CLEAR: if (sts.clear_last) state_q <= S_IDLE;
				S_IDLE:  if (in_valid) state_q <= S_HASH1;
				S_HASH1: state_q <= S_HASH2;
				S_HASH2: state_q <= S_READ;
				S_READ:  state_q <= S_CHECK;
				S_CHECK: if (sts.check_done) state_q <= S_OUT;
				S_OUT:   if (sts.out_free) state_q <= S_IDLE;
				default: state_q <= S_CLEAR;
			endcase
		end
	end

	always_comb begin
		cmd          = '0;
		cmd.clear    = (state_q == S_CLEAR);
		cmd.load_in  = (state_q == S_IDLE) && in_valid;
		cmd.hash1    = (state_q == S_HASH1);
		cmd.hash2    = (state_q == S_HASH2);
		cmd.read     = (state_q == S_READ);
		cmd.check    = (state_q == S_CHECK);
		cmd.load_out = (state_q == S_OUT) && sts.out_free;
	end

	assign in_ready = (state_q == S_IDLE);

endmodule

[design/ohash_dp.sv]
// ----------------------------------------------------------------------------
// ohash_dp
// Datapath: slot count register, two-step multiplicative hash, slot memory
// with registered read, probe compare, result and output registers.
// ----------------------------------------------------------------------------
module ohash_dp #(
	parameter int TABLE_SLOTS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ohash_pkg::ctl_cmd_t          cmd,
	output ohash_pkg::ctl_sts_t          sts,
	input  logic                         cfg_wr_en,
	input  logic [ohash_pkg::CFG_W-1:0]  cfg_wr_data,
	input  logic [ohash_pkg::ACT_W-1:0]  action,
	input  logic [ohash_pkg::KEY_W-1:0]  key,
	input  logic [ohash_pkg::PAY_W-1:0]  payload,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [ohash_pkg::ST_W-1:0]   status,
	output logic [ohash_pkg::SLOT_W-1:0] slot,
	output logic [ohash_pkg::PAY_W-1:0]  found_payload
);
	import ohash_pkg::*;

	localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int CW    = IDX_W + 1;
	localparam int P1W   = KEY_W + 32;
	localparam int P2W   = 32 + CW;
	localparam logic [IDX_W-1:0] LAST_ROW = IDX_W'(TABLE_SLOTS - 1);

	entry_t mem [TABLE_SLOTS];

	logic [CFG_W-1:0] cfg_q;
	logic [ACT_W-1:0] act_q;
	logic [KEY_W-1:0] key_q;
	logic [PAY_W-1:0] pay_q;
	logic [CW-1:0]    n_q;
	logic [31:0]      frac_q;
	logic [IDX_W-1:0] idx_q;
	logic [CW-1:0]    cnt_q;
	logic [IDX_W-1:0] clr_q;
	entry_t           rd_q;

	logic [ST_W-1:0]   res_status_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic [PAY_W-1:0]  res_found_q;
	logic              out_valid_q;
	logic [ST_W-1:0]   out_status_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic [PAY_W-1:0]  out_found_q;

	logic [CW-1:0]    n_new;
	logic [P1W-1:0]   prod1;
	logic [P2W-1:0]   prod2;
	logic [CW-1:0]    idx_inc;
	logic [IDX_W-1:0] idx_nxt;
	logic             last_probe;
	logic [IDX_W-1:0] rd_addr;
	logic             mem_we;
	logic [IDX_W-1:0] mem_wa;
	entry_t           mem_wd;
	logic             done;
	logic             wr_hit;
	entry_t           wr_entry;
	logic [ST_W-1:0]  c_status;
	logic [PAY_W-1:0] c_found;

	// slot count in use, clamped to 1 .. TABLE_SLOTS
	always_comb begin
		if (cfg_q == '0) begin
			n_new = CW'(1);
		end else if (32'(cfg_q) > TABLE_SLOTS) begin
			n_new = CW'(TABLE_SLOTS);
		end else begin
			n_new = CW'(cfg_q);
		end
	end

	assign prod1 = P1W'(key_q) * P1W'(GOLDEN_Q32);
	assign prod2 = P2W'(frac_q) * P2W'(n_q);

	assign idx_inc    = CW'(idx_q) + CW'(1);
	assign idx_nxt    = (idx_inc == n_q) ? '0 : idx_inc[IDX_W-1:0];
	assign last_probe = (CW'(cnt_q + CW'(1)) == n_q);
	assign rd_addr    = cmd.check ? idx_nxt : idx_q;

	// probe decision on the entry read for idx_q
	always_comb begin
		done     = 1'b0;
		wr_hit   = 1'b0;
		wr_entry = rd_q;
		c_status = ST_MISSING;
		c_found  = '0;
		case (act_q)
			ACT_INSERT: begin
				if (rd_q.mark != MARK_USED) begin
					done             = 1'b1;
					wr_hit           = 1'b1;
					wr_entry.mark    = MARK_USED;
					wr_entry.key     = key_q;
					wr_entry.payload = pay_q;
					c_status         = ST_OK;
				end
			end
			ACT_DELETE: begin
				if (rd_q.mark == MARK_EMPTY) begin
					done = 1'b1;
				end else if (rd_q.mark == MARK_USED && rd_q.key == key_q) begin
					done          = 1'b1;
					wr_hit        = 1'b1;
					wr_entry.mark = MARK_DELETED;
					c_status      = ST_OK;
				end
			end
			ACT_SEARCH: begin
				if (rd_q.mark == MARK_EMPTY) begin
					done = 1'b1;
				end else if (rd_q.mark == MARK_USED && rd_q.key == key_q) begin
					done     = 1'b1;
					c_status = ST_OK;
					c_found  = rd_q.payload;
				end
			end
			default: begin
				done = 1'b1;
			end
		endcase
		// a full round without a stop
		if (!done && last_probe) begin
			done     = 1'b1;
			c_status = (act_q == ACT_INSERT) ? ST_FULL : ST_MISSING;
		end
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = idx_q;
		mem_wd = wr_entry;
		if (cmd.clear) begin
			mem_we = 1'b1;
			mem_wa = clr_q;
			mem_wd = '{mark: MARK_EMPTY, key: '0, payload: '0};
		end else if (cmd.check && wr_hit) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (cmd.read || cmd.check) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q       <= CFG_RESET;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				cfg_q <= cfg_wr_data;
			end
			if (cmd.clear) begin
				clr_q <= clr_q + IDX_W'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			act_q <= action;
			key_q <= key;
			pay_q <= payload;
			n_q   <= n_new;
		end
		if (cmd.hash1) begin
			frac_q <= prod1[31:0];
		end
		if (cmd.hash2) begin
			idx_q <= prod2[32 +: IDX_W];
			cnt_q <= '0;
		end
		if (cmd.check) begin
			if (done) begin
				res_status_q <= c_status;
				res_slot_q   <= (c_status == ST_OK) ? SLOT_W'(idx_q) : '0;
				res_found_q  <= c_found;
			end else begin
				idx_q <= idx_nxt;
				cnt_q <= cnt_q + CW'(1);
			end
		end
		if (cmd.load_out) begin
			out_status_q <= res_status_q;
			out_slot_q   <= res_slot_q;
			out_found_q  <= res_found_q;
		end
	end

	assign sts.clear_last = (clr_q == LAST_ROW);
	assign sts.check_done = done;
	assign sts.out_free   = !out_valid_q || out_ready;

	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign slot          = out_slot_q;
	assign found_payload = out_found_q;

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.check |-> (CW'(idx_q) < n_q))
		else $error("probe index beyond slot count");

	a_cnt_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.check |-> (cnt_q < n_q))
		else $error("probe count beyond slot count");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("output register overwritten");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid)
		else $error("loaded result not presented");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (cmd.clear || cmd.check))
		else $error("slot memory written outside clear or probe");

endmodule

[design/open_addressing_hash_table.sv]
// ----------------------------------------------------------------------------
// open_addressing_hash_table
// sequence: two hash steps and a memory read after an item is accepted, then
//   p probes (1 .. n, n = slots in use), one memory probe per cycle; out_valid
//   rises once the output register is free; the next item is accepted only
//   after that, but a waiting result does not block its acceptance
// reset: a clearing pass marks every slot empty, no item accepted meanwhile;
//   slot count register resets to 8, writable at any time
// ----------------------------------------------------------------------------
module open_addressing_hash_table #(
	parameter int TABLE_SLOTS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [ohash_pkg::CFG_W-1:0]  cfg_wr_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [ohash_pkg::ACT_W-1:0]  action,
	input  logic [ohash_pkg::KEY_W-1:0]  key,
	input  logic [ohash_pkg::PAY_W-1:0]  payload,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [ohash_pkg::ST_W-1:0]   status,
	output logic [ohash_pkg::SLOT_W-1:0] slot,
	output logic [ohash_pkg::PAY_W-1:0]  found_payload
);
	import ohash_pkg::*;

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	ohash_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ohash_dp #(
		.TABLE_SLOTS (TABLE_SLOTS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.action        (action),
		.key           (key),
		.payload       (payload),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.slot          (slot),
		.found_payload (found_payload)
	);

endmodule
